// File: src/assert_macros.svh
// Assertion helpers used by arpc_ctrl. Each use expects clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge outside reset.
`define ARPC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check that a condition never holds on a rising edge outside reset.
`define ARPC_NEVER(lbl, cond, msg) \
  `ARPC_ASSERT(lbl, !(cond), msg)

`endif

// File: src/arpc_pkg.sv
package arpc_pkg;

  localparam int IP_W       = 32;
  localparam int MAC_W      = 48;
  localparam int LIMIT_W    = 5;
  localparam int SLOT_W     = 4;
  localparam int COUNT_W    = 5;
  localparam int IN_TDATA_W  = 88;
  localparam int OUT_TDATA_W = 96;

  // most results a single dump may return
  localparam logic [LIMIT_W-1:0] MAX_RESULTS = 5'd16;

  typedef enum logic [1:0] {
    CMD_LOOKUP = 2'd0,
    CMD_ADD    = 2'd1,
    CMD_DUMP   = 2'd2
  } cmd_t;

  typedef enum logic [2:0] {
    STS_HIT        = 3'd0,
    STS_MISS       = 3'd1,
    STS_UPDATED    = 3'd2,
    STS_INSERTED   = 3'd3,
    STS_DROPPED    = 3'd4,
    STS_DUMP_ENTRY = 3'd5,
    STS_DUMP_EMPTY = 3'd6
  } status_t;

  typedef struct packed {
    logic             valid;
    logic [IP_W-1:0]  ip;
    logic [MAC_W-1:0] mac;
  } entry_t;

  // ring control from the sequencer to the cells
  typedef struct packed {
    logic   shift;
    logic   load;
    entry_t wr_entry;
  } ring_ctl_t;

endpackage

// File: src/arp_cache_table.sv
// Channel   Dir  Handshake               Payload
// in_       in   in_tvalid / in_tready   tuser: command; tdata: ip, mac, dump limit
// out_      out  out_tvalid / out_tready tuser: status; tdata: ip, mac, slot, count
//
// Lookup, dump and a dropped add: one scan pass, then the flush state registers the last result and
// the sequencer returns to idle; an add that writes takes a second pass, the write pass, before flush.
// Each pass rotates the entries once through the ring of cells, one slot per cycle unless a dump stall holds it.
// One item at a time: in_tready is high only while the sequencer is idle.
// Reset (rst_n low, synchronous) clears all valid bits at once; no sweep is needed.
// A busy output register freezes a dump pass and delays the final result; nothing drops.
module arp_cache_table
  import arpc_pkg::*;
#(
  parameter int ENTRIES = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // ip_address, mac_address, dump_limit
  input  logic [1:0]             in_tuser,   // command
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // result_ip, result_mac, slot_index, entry_count
  output logic [2:0]             out_tuser,  // status
  output logic                   out_tlast
);

  // cell k holds slot k between items; during a pass the ring rotates toward
  // cell 0 (the head) and cell ENTRIES-1 takes the head's entry back in
  entry_t    cell_q   [ENTRIES];
  ring_ctl_t ring_ctl;

  logic [SLOT_W-1:0]  res_slot;
  logic [COUNT_W-1:0] res_count;
  logic [IP_W-1:0]    res_ip;
  logic [MAC_W-1:0]   res_mac;

  for (genvar k = 0; k < ENTRIES; k++) begin : g_cell
    ring_ctl_t cell_ctl;

    // only the tail cell takes a write
    always_comb begin
      cell_ctl      = ring_ctl;
      cell_ctl.load = (k == ENTRIES - 1) ? ring_ctl.load : 1'b0;
    end

    arpc_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .ctl   (cell_ctl),
      .d     (cell_q[(k + 1) % ENTRIES]),
      .q     (cell_q[k])
    );
  end

  arpc_ctrl #(
    .ENTRIES (ENTRIES)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_command (in_tuser),
    .in_ip      (in_tdata[31:0]),
    .in_mac     (in_tdata[79:32]),
    .in_limit   (in_tdata[84:80]),
    .head       (cell_q[0]),
    .ring_ctl   (ring_ctl),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_status (out_tuser),
    .out_ip     (res_ip),
    .out_mac    (res_mac),
    .out_slot   (res_slot),
    .out_count  (res_count),
    .out_last   (out_tlast)
  );

  // pack result fields from the lowest bit up, pad to whole bytes
  assign out_tdata = {7'b0, res_count, res_slot, res_mac, res_ip};

endmodule

// File: src/arpc_cell.sv
module arpc_cell
  import arpc_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  ring_ctl_t ctl,
  input  entry_t    d,
  output entry_t    q
);

  logic             valid_r;
  logic [IP_W-1:0]  ip_r;
  logic [MAC_W-1:0] mac_r;

  // valid bit clears on reset, the payload waits for its first write
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ctl.shift) begin
      valid_r <= ctl.load ? ctl.wr_entry.valid : d.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.shift) begin
      ip_r  <= ctl.load ? ctl.wr_entry.ip  : d.ip;
      mac_r <= ctl.load ? ctl.wr_entry.mac : d.mac;
    end
  end

  assign q = '{valid: valid_r, ip: ip_r, mac: mac_r};

endmodule

// File: src/arpc_ctrl.sv
`include "assert_macros.svh"

module arpc_ctrl
  import arpc_pkg::*;
#(
  parameter int ENTRIES = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_command,
  input  logic [IP_W-1:0]    in_ip,
  input  logic [MAC_W-1:0]   in_mac,
  input  logic [LIMIT_W-1:0] in_limit,
  input  entry_t             head,
  output ring_ctl_t          ring_ctl,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [2:0]         out_status,
  output logic [IP_W-1:0]    out_ip,
  output logic [MAC_W-1:0]   out_mac,
  output logic [SLOT_W-1:0]  out_slot,
  output logic [COUNT_W-1:0] out_count,
  output logic               out_last
);

  localparam int IDXW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam logic [IDXW-1:0] LAST_STEP = IDXW'(ENTRIES - 1);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_SCAN  = 4'b0010,
    ST_WRITE = 4'b0100,
    ST_FLUSH = 4'b1000
  } state_t;

  function automatic logic [SLOT_W-1:0] slot4(input logic [IDXW-1:0] idx);
    logic [IDXW+SLOT_W-1:0] ext;
    ext = {{SLOT_W{1'b0}}, idx};
    return ext[SLOT_W-1:0];
  endfunction

  state_t             state_r, state_nxt;
  cmd_t               cmd_r, cmd_nxt;
  logic [IP_W-1:0]    ip_r, ip_nxt;
  logic [MAC_W-1:0]   new_mac_r, new_mac_nxt;
  logic [LIMIT_W-1:0] lim_r, lim_nxt;
  logic [COUNT_W-1:0] cnt_r, cnt_nxt;
  logic [IDXW-1:0]    step_r, step_nxt;
  logic               found_r, found_nxt;
  logic [IDXW-1:0]    hit_idx_r, hit_idx_nxt;
  logic [MAC_W-1:0]   hit_mac_r, hit_mac_nxt;
  logic               free_r, free_nxt;
  logic [IDXW-1:0]    free_idx_r, free_idx_nxt;
  logic               pend_r, pend_nxt;
  logic [IP_W-1:0]    pend_ip_r, pend_ip_nxt;
  logic [MAC_W-1:0]   pend_mac_r, pend_mac_nxt;
  logic [IDXW-1:0]    pend_idx_r, pend_idx_nxt;

  logic               out_valid_r, out_valid_nxt;
  logic [2:0]         out_status_r, out_status_nxt;
  logic [IP_W-1:0]    out_ip_r, out_ip_nxt;
  logic [MAC_W-1:0]   out_mac_r, out_mac_nxt;
  logic [SLOT_W-1:0]  out_slot_r, out_slot_nxt;
  logic [COUNT_W-1:0] out_count_r, out_count_nxt;
  logic               out_last_r, out_last_nxt;

  logic            out_free;
  logic            head_match;
  logic            dump_take;
  logic            stall;
  logic            last_step;
  logic [IDXW-1:0] wr_idx;

  assign out_free   = !out_valid_r || out_ready;
  assign head_match = head.valid && (head.ip == ip_r);
  assign dump_take  = (cmd_r == CMD_DUMP) && head.valid && (cnt_r < lim_r);
  // a new dump entry must push the held one out first
  assign stall      = (state_r == ST_SCAN) && dump_take && pend_r && !out_free;
  assign last_step  = (step_r == LAST_STEP);
  assign wr_idx     = found_r ? hit_idx_r : free_idx_r;

  assign in_ready = (state_r == ST_IDLE);

  always_comb begin
    ring_ctl.shift    = ((state_r == ST_SCAN) && !stall) || (state_r == ST_WRITE);
    ring_ctl.load     = (state_r == ST_WRITE) && (step_r == wr_idx);
    ring_ctl.wr_entry = '{valid: 1'b1, ip: ip_r, mac: new_mac_r};
  end

  always_comb begin
    state_nxt      = state_r;
    cmd_nxt        = cmd_r;
    ip_nxt         = ip_r;
    new_mac_nxt    = new_mac_r;
    lim_nxt        = lim_r;
    cnt_nxt        = cnt_r;
    step_nxt       = step_r;
    found_nxt      = found_r;
    hit_idx_nxt    = hit_idx_r;
    hit_mac_nxt    = hit_mac_r;
    free_nxt       = free_r;
    free_idx_nxt   = free_idx_r;
    pend_nxt       = pend_r;
    pend_ip_nxt    = pend_ip_r;
    pend_mac_nxt   = pend_mac_r;
    pend_idx_nxt   = pend_idx_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_status_nxt = out_status_r;
    out_ip_nxt     = out_ip_r;
    out_mac_nxt    = out_mac_r;
    out_slot_nxt   = out_slot_r;
    out_count_nxt  = out_count_r;
    out_last_nxt   = out_last_r;

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd_nxt     = cmd_t'(in_command);
          ip_nxt      = in_ip;
          new_mac_nxt = in_mac;
          lim_nxt     = (in_limit > MAX_RESULTS) ? MAX_RESULTS : in_limit;
          cnt_nxt     = '0;
          step_nxt    = '0;
          found_nxt   = 1'b0;
          free_nxt    = 1'b0;
          pend_nxt    = 1'b0;
          // unused command code: drop the item
          case (in_command)
            CMD_LOOKUP, CMD_ADD, CMD_DUMP: state_nxt = ST_SCAN;
            default:                       state_nxt = ST_IDLE;
          endcase
        end
      end

      ST_SCAN: begin
        if (!stall) begin
          if (cmd_r != CMD_DUMP) begin
            if (head_match && !found_r) begin
              found_nxt   = 1'b1;
              hit_idx_nxt = step_r;
              hit_mac_nxt = head.mac;
            end
            if (!head.valid && !free_r) begin
              free_nxt     = 1'b1;
              free_idx_nxt = step_r;
            end
          end else if (dump_take) begin
            if (pend_r) begin
              out_valid_nxt  = 1'b1;
              out_status_nxt = STS_DUMP_ENTRY;
              out_ip_nxt     = pend_ip_r;
              out_mac_nxt    = pend_mac_r;
              out_slot_nxt   = slot4(pend_idx_r);
              out_count_nxt  = cnt_r;
              out_last_nxt   = 1'b0;
            end
            pend_nxt     = 1'b1;
            pend_ip_nxt  = head.ip;
            pend_mac_nxt = head.mac;
            pend_idx_nxt = step_r;
            cnt_nxt      = cnt_r + 1'b1;
          end
          if (last_step) begin
            step_nxt = '0;
            if ((cmd_r == CMD_ADD) && (found_nxt || free_nxt)) begin
              state_nxt = ST_WRITE;
            end else begin
              state_nxt = ST_FLUSH;
            end
          end else begin
            step_nxt = step_r + 1'b1;
          end
        end
      end

      ST_WRITE: begin
        if (last_step) begin
          step_nxt  = '0;
          state_nxt = ST_FLUSH;
        end else begin
          step_nxt = step_r + 1'b1;
        end
      end

      ST_FLUSH: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_last_nxt   = 1'b1;
          out_ip_nxt     = '0;
          out_mac_nxt    = '0;
          out_slot_nxt   = '0;
          out_count_nxt  = '0;
          state_nxt      = ST_IDLE;
          case (cmd_r)
            CMD_LOOKUP: begin
              if (found_r) begin
                out_status_nxt = STS_HIT;
                out_mac_nxt    = hit_mac_r;
                out_slot_nxt   = slot4(hit_idx_r);
              end else begin
                out_status_nxt = STS_MISS;
              end
            end
            CMD_ADD: begin
              if (found_r) begin
                out_status_nxt = STS_UPDATED;
                out_slot_nxt   = slot4(hit_idx_r);
              end else if (free_r) begin
                out_status_nxt = STS_INSERTED;
                out_slot_nxt   = slot4(free_idx_r);
              end else begin
                out_status_nxt = STS_DROPPED;
              end
            end
            default: begin
              if (pend_r) begin
                out_status_nxt = STS_DUMP_ENTRY;
                out_ip_nxt     = pend_ip_r;
                out_mac_nxt    = pend_mac_r;
                out_slot_nxt   = slot4(pend_idx_r);
                out_count_nxt  = cnt_r;
              end else begin
                out_status_nxt = STS_DUMP_EMPTY;
              end
            end
          endcase
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      step_r      <= '0;
      cnt_r       <= '0;
      lim_r       <= '0;
      found_r     <= 1'b0;
      free_r      <= 1'b0;
      pend_r      <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      step_r      <= step_nxt;
      cnt_r       <= cnt_nxt;
      lim_r       <= lim_nxt;
      found_r     <= found_nxt;
      free_r      <= free_nxt;
      pend_r      <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r        <= cmd_nxt;
    ip_r         <= ip_nxt;
    new_mac_r    <= new_mac_nxt;
    hit_idx_r    <= hit_idx_nxt;
    hit_mac_r    <= hit_mac_nxt;
    free_idx_r   <= free_idx_nxt;
    pend_ip_r    <= pend_ip_nxt;
    pend_mac_r   <= pend_mac_nxt;
    pend_idx_r   <= pend_idx_nxt;
    out_status_r <= out_status_nxt;
    out_ip_r     <= out_ip_nxt;
    out_mac_r    <= out_mac_nxt;
    out_slot_r   <= out_slot_nxt;
    out_count_r  <= out_count_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;
  assign out_ip     = out_ip_r;
  assign out_mac    = out_mac_r;
  assign out_slot   = out_slot_r;
  assign out_count  = out_count_r;
  assign out_last   = out_last_r;

  `ARPC_NEVER(a_idle_no_shift, ring_ctl.shift && (state_r == ST_IDLE), "ring moved while idle")
  `ARPC_ASSERT(a_load_in_write, ring_ctl.load |-> (state_r == ST_WRITE), "load outside write pass")
  `ARPC_ASSERT(a_count_in_limit, (cnt_r <= lim_r), "dump count passed its limit")
  `ARPC_ASSERT(a_flush_emits, (state_r == ST_FLUSH && out_free) |=> (state_r == ST_IDLE && out_valid_r), "flush did not emit")

endmodule
